[rtl/ifr_pkg.sv]
// ----------------------------------------------------------------------------
// ifr_pkg
// Shared types and constants of the interface frame rotation core.
// ----------------------------------------------------------------------------
package ifr_pkg;

   // square root steps, one result bit per stage
   localparam int unsigned SQRT_LAT  = 32;
   // divider: operand stage, one quotient bit per stage, sign and saturation stage
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_LAT   = DIV_STEPS + 2;

   // 1e-8 in Q2.60, rounded up
   localparam logic [63:0] TINY_H2 = 64'd11529215047;
   localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

   typedef struct packed {
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } ifr_req_type;

   typedef struct packed {
      logic signed [31:0] strike_x;
      logic signed [31:0] strike_y;
      logic signed [31:0] strike_z;
      logic signed [31:0] dip_x;
      logic signed [31:0] dip_y;
      logic signed [31:0] dip_z;
      logic signed [31:0] axis_n_x;
      logic signed [31:0] axis_n_y;
      logic signed [31:0] axis_n_z;
      logic signed [31:0] local_first;
      logic signed [31:0] local_second;
      logic signed [31:0] local_third;
   } ifr_rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      ifr_req_type req;
      logic [63:0] h2;
      logic [63:0] n2;
      logic        tiny;
      logic        sx_neg;
      logic [31:0] sx_mag;
      logic        sy_neg;
      logic [31:0] sy_mag;
   } ifr_item_type;

   // side data riding along the square root stages
   typedef struct packed {
      ifr_req_type req;
      logic        tiny;
      logic        sx_neg;
      logic [31:0] sx_mag;
      logic        sy_neg;
      logic [31:0] sy_mag;
   } ifr_l1_type;

   // side data riding along the strike dividers
   typedef struct packed {
      ifr_req_type req;
      logic        tiny;
      logic [31:0] h;
      logic [31:0] m;
   } ifr_l2_type;

   // side data after the strike axis is known
   typedef struct packed {
      ifr_req_type        req;
      logic               tiny;
      logic [31:0]        h;
      logic [31:0]        m;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
   } ifr_l3_type;

   // side data riding along the dip dividers
   typedef struct packed {
      ifr_req_type        req;
      logic               tiny;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
   } ifr_l4_type;

endpackage

[rtl/ifr_delay.sv]
// ----------------------------------------------------------------------------
// ifr_delay
// Stalling delay line with reset valid bits, aligns side data to a unit.
// ----------------------------------------------------------------------------
module ifr_delay #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // payload taps
   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign out_data  = data_ff[DEPTH-1];

endmodule

[rtl/ifr_sqrt.sv]
// ----------------------------------------------------------------------------
// ifr_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module ifr_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import ifr_pkg::*;

   logic [33:0] rem_ff  [SQRT_LAT-1];
   logic [63:0] rad_ff  [SQRT_LAT-1];
   logic [31:0] root_ff [SQRT_LAT];

   for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
      logic [33:0] rem_prev;
      logic [31:0] root_prev;
      logic [63:0] rad_prev;
      logic [33:0] rem_sh;
      logic [33:0] trial;
      logic        take;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      // bring down the next bit pair and try root*4+1
      assign rem_sh = {rem_prev[31:0], rad_prev[63:62]};
      assign trial  = {root_prev, 2'b01};
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= {root_prev[30:0], take};
         end
      end

      if (k < SQRT_LAT - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= take ? (rem_sh - trial) : rem_sh;
               rad_ff[k] <= {rad_prev[61:0], 2'b00};
            end
         end
      end
   end

   assign root = root_ff[SQRT_LAT-1];

endmodule

[rtl/ifr_div.sv]
// ----------------------------------------------------------------------------
// ifr_div
// Pipelined sign-magnitude division, rounded half away from zero and
// saturated to 32 bits signed, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ifr_div (
   input  logic               clock,
   input  logic               en,
   input  logic               num_neg,
   input  logic [62:0]        num_mag,
   input  logic [31:0]        den,
   output logic signed [31:0] quot
);
   import ifr_pkg::*;

   logic               neg_ff [DIV_STEPS+1];
   logic               ovf_ff [DIV_STEPS+1];
   logic [31:0]        rem_ff [DIV_STEPS];
   logic [31:0]        low_ff [DIV_STEPS];
   logic [31:0]        den_ff [DIV_STEPS];
   logic [31:0]        q_ff   [DIV_STEPS];
   logic signed [31:0] quot_ff;
   logic [63:0]        biased;
   logic [31:0]        q_last;
   logic               big_neg;
   logic signed [31:0] quot_in;

   // operand stage: add half the divisor, flag quotients of 2^32 and up
   assign biased = {1'b0, num_mag} + {33'd0, den[31:1]};

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= num_neg;
         ovf_ff[0] <= (biased[63:32] >= den);
         rem_ff[0] <= biased[63:32];
         low_ff[0] <= biased[31:0];
         den_ff[0] <= den;
      end
   end

   // restoring division steps
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [32:0] rem_sh;
      logic [32:0] diff;
      logic        take;
      logic [31:0] q_prev;

      assign rem_sh = {rem_ff[k-1], low_ff[k-1][31]};
      assign diff   = rem_sh - {1'b0, den_ff[k-1]};
      assign take   = (rem_sh >= {1'b0, den_ff[k-1]});

      if (k == 1) begin : g_first
         assign q_prev = '0;
      end else begin : g_next
         assign q_prev = q_ff[k-2];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k-1] <= {q_prev[30:0], take};
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end

      if (k < DIV_STEPS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= take ? diff[31:0] : rem_sh[31:0];
               low_ff[k] <= {low_ff[k-1][30:0], 1'b0};
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   // sign and saturation
   assign q_last  = q_ff[DIV_STEPS-1];
   assign big_neg = ovf_ff[DIV_STEPS] || (q_last[31] && (q_last[30:0] != '0));

   always_comb begin
      if (neg_ff[DIV_STEPS]) begin
         quot_in = big_neg ? 32'sh8000_0000 : $signed(-q_last);
      end else begin
         quot_in = (ovf_ff[DIV_STEPS] || q_last[31]) ? 32'sh7FFF_FFFF : $signed(q_last);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

[rtl/ifr_queue.sv]
// ----------------------------------------------------------------------------
// ifr_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module ifr_queue #(
   parameter int unsigned DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ifr_pkg::ifr_item_type push_item,
   input  logic                  pop,
   output logic                  empty,
   output ifr_pkg::ifr_item_type pop_item
);
   import ifr_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   ifr_item_type  mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff;
   logic [AW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_pop;

   assign do_pop = pop && !empty;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         count_ff <= count_ff + CW'(push) - CW'(do_pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   // the front's credit must keep the queue from overrunning
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && !do_pop && (count_ff == CW'(DEPTH))))
      else $error("queue written while full");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

endmodule

[rtl/ifr_front.sv]
// ----------------------------------------------------------------------------
// ifr_front
// Accepts transactions, squares the normal and classifies the horizontal
// part; keeps a credit count over its own stages and the queue.
// ----------------------------------------------------------------------------
module ifr_front #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ifr_pkg::ifr_req_type  req_data,
   output logic                  full,
   output logic                  q_push,
   output ifr_pkg::ifr_item_type q_item,
   input  logic                  q_pop
);
   import ifr_pkg::*;

   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   logic               accept;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      cnt_in;
   logic               a_valid_ff;
   ifr_req_type        a_req_ff;
   logic [63:0]        a_sqx_ff;
   logic [63:0]        a_sqy_ff;
   logic [63:0]        a_sqz_ff;
   logic signed [63:0] sqx_in;
   logic signed [63:0] sqy_in;
   logic signed [63:0] sqz_in;
   logic               b_valid_ff;
   ifr_item_type       b_item_ff;
   ifr_item_type       b_item_in;
   logic [63:0]        h2;

   assign accept = push && !full;
   assign full   = (cnt_ff == CW'(QUEUE_DEPTH));

   // transactions held in the front stages or in the queue
   assign cnt_in = cnt_ff + CW'(accept) - CW'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
      end
   end

   // stage a: squares of the normal
   assign sqx_in = $signed(req_data.normal_x) * $signed(req_data.normal_x);
   assign sqy_in = $signed(req_data.normal_y) * $signed(req_data.normal_y);
   assign sqz_in = $signed(req_data.normal_z) * $signed(req_data.normal_z);

   always_ff @(posedge clock) begin
      a_req_ff <= req_data;
      a_sqx_ff <= sqx_in;
      a_sqy_ff <= sqy_in;
      a_sqz_ff <= sqz_in;
   end

   // stage b: horizontal test and strike numerator signs
   assign h2 = a_sqx_ff + a_sqy_ff;

   always_comb begin
      b_item_in        = '0;
      b_item_in.req    = a_req_ff;
      b_item_in.h2     = h2;
      b_item_in.n2     = h2 + a_sqz_ff;
      b_item_in.tiny   = (h2 < TINY_H2);
      // strike x numerator is -ny, strike y numerator is nx
      b_item_in.sx_neg = !a_req_ff.normal_y[31] && (a_req_ff.normal_y != '0);
      b_item_in.sx_mag = a_req_ff.normal_y[31] ? 32'(-a_req_ff.normal_y)
                                               : 32'(a_req_ff.normal_y);
      b_item_in.sy_neg = a_req_ff.normal_x[31];
      b_item_in.sy_mag = a_req_ff.normal_x[31] ? 32'(-a_req_ff.normal_x)
                                               : 32'(a_req_ff.normal_x);
   end

   always_ff @(posedge clock) begin
      b_item_ff <= b_item_in;
   end

   assign q_push = b_valid_ff;
   assign q_item = b_item_ff;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QUEUE_DEPTH))
      else $error("front credit count above queue depth");

   a_credit_covers_stages: assert property (@(posedge clock) disable iff (reset)
      (CW'(a_valid_ff) + CW'(b_valid_ff)) <= cnt_ff)
      else $error("front stages hold more than the credit count");

endmodule

[rtl/ifr_back.sv]
// ----------------------------------------------------------------------------
// ifr_back
// Executes classified transactions: square roots, strike and dip divisions,
// frame selection and the three saturated projections.
// ----------------------------------------------------------------------------
module ifr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  ifr_pkg::ifr_item_type q_item,
   output logic                  q_pop,
   input  logic                  pop,
   output logic                  empty,
   output ifr_pkg::ifr_rsp_type  rsp_data
);
   import ifr_pkg::*;

   function automatic logic signed [31:0] dot_round(
      input logic signed [63:0] p0,
      input logic signed [63:0] p1,
      input logic signed [63:0] p2
   );
      logic signed [65:0] sum;
      logic signed [35:0] shf;
      sum = 66'(p0) + 66'(p1) + 66'(p2) + 66'sd536870912;
      shf = 36'(sum >>> 30);
      if (shf > 36'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (shf < -36'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return 32'(shf);
   endfunction

   logic               adv;
   ifr_l1_type         l1_in;
   logic               a_valid;
   logic [$bits(ifr_l1_type)-1:0] a_bits;
   ifr_l1_type         a_data;
   logic [31:0]        root_h;
   logic [31:0]        root_m;
   ifr_l2_type         l2_in;
   logic               b_valid;
   logic [$bits(ifr_l2_type)-1:0] b_bits;
   ifr_l2_type         b_data;
   logic signed [31:0] b_sx;
   logic signed [31:0] b_sy;
   logic               c_valid_ff;
   ifr_l3_type         c_data_ff;
   logic signed [63:0] c_px_ff;
   logic signed [63:0] c_py_ff;
   logic               d_valid_ff;
   ifr_l3_type         d_data_ff;
   logic               d_xneg_ff;
   logic [62:0]        d_xmag_ff;
   logic               d_yneg_ff;
   logic [62:0]        d_ymag_ff;
   ifr_l4_type         l4_in;
   logic               e_valid;
   logic [$bits(ifr_l4_type)-1:0] e_bits;
   ifr_l4_type         e_data;
   logic signed [31:0] e_dx;
   logic signed [31:0] e_dy;
   logic signed [31:0] e_dz;
   logic               f_valid_ff;
   ifr_rsp_type        f_frame_ff;
   ifr_rsp_type        f_frame_in;
   logic signed [63:0] f_ps_ff [2];
   logic signed [63:0] f_pd_ff [3];
   logic signed [63:0] f_pn_ff [3];
   logic               rsp_valid_ff;
   ifr_rsp_type        rsp_ff;
   ifr_rsp_type        rsp_in;

   // whole back pipeline moves unless a result waits at the output
   assign adv   = !rsp_valid_ff || pop;
   assign q_pop = adv && !q_empty;

   // square roots of the horizontal and full squared norms
   always_comb begin
      l1_in        = '0;
      l1_in.req    = q_item.req;
      l1_in.tiny   = q_item.tiny;
      l1_in.sx_neg = q_item.sx_neg;
      l1_in.sx_mag = q_item.sx_mag;
      l1_in.sy_neg = q_item.sy_neg;
      l1_in.sy_mag = q_item.sy_mag;
   end

   ifr_sqrt u_sqrt_h (.clock(clock), .en(adv), .radicand(q_item.h2), .root(root_h));
   ifr_sqrt u_sqrt_m (.clock(clock), .en(adv), .radicand(q_item.n2), .root(root_m));

   ifr_delay #(.WIDTH($bits(ifr_l1_type)), .DEPTH(SQRT_LAT)) u_line_a (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(!q_empty), .in_data(l1_in),
      .out_valid(a_valid), .out_data(a_bits)
   );
   assign a_data = a_bits;

   // strike axis: -ny/h and nx/h in Q1.30
   always_comb begin
      l2_in      = '0;
      l2_in.req  = a_data.req;
      l2_in.tiny = a_data.tiny;
      l2_in.h    = root_h;
      l2_in.m    = root_m;
   end

   ifr_div u_div_sx (
      .clock(clock), .en(adv), .num_neg(a_data.sx_neg),
      .num_mag({1'b0, a_data.sx_mag, 30'd0}), .den(root_h), .quot(b_sx)
   );
   ifr_div u_div_sy (
      .clock(clock), .en(adv), .num_neg(a_data.sy_neg),
      .num_mag({1'b0, a_data.sy_mag, 30'd0}), .den(root_h), .quot(b_sy)
   );

   ifr_delay #(.WIDTH($bits(ifr_l2_type)), .DEPTH(DIV_LAT)) u_line_b (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(a_valid), .in_data(l2_in),
      .out_valid(b_valid), .out_data(b_bits)
   );
   assign b_data = b_bits;

   // stage c: nz times strike components
   always_ff @(posedge clock) begin
      if (adv) begin
         c_data_ff.req  <= b_data.req;
         c_data_ff.tiny <= b_data.tiny;
         c_data_ff.h    <= b_data.h;
         c_data_ff.m    <= b_data.m;
         c_data_ff.sx   <= b_sx;
         c_data_ff.sy   <= b_sy;
         c_px_ff        <= $signed(b_data.req.normal_z) * $signed(b_sy);
         c_py_ff        <= $signed(b_data.req.normal_z) * $signed(b_sx);
      end
   end

   // stage d: dip numerators to sign and magnitude (dip x is -nz*sy)
   always_ff @(posedge clock) begin
      if (adv) begin
         d_data_ff <= c_data_ff;
         d_xneg_ff <= !c_px_ff[63] && (c_px_ff != '0);
         d_xmag_ff <= c_px_ff[63] ? 63'(-c_px_ff) : 63'(c_px_ff);
         d_yneg_ff <= c_py_ff[63];
         d_ymag_ff <= c_py_ff[63] ? 63'(-c_py_ff) : 63'(c_py_ff);
      end
   end

   // dip axis divided by the full norm
   always_comb begin
      l4_in      = '0;
      l4_in.req  = d_data_ff.req;
      l4_in.tiny = d_data_ff.tiny;
      l4_in.sx   = d_data_ff.sx;
      l4_in.sy   = d_data_ff.sy;
   end

   ifr_div u_div_dx (
      .clock(clock), .en(adv), .num_neg(d_xneg_ff),
      .num_mag(d_xmag_ff), .den(d_data_ff.m), .quot(e_dx)
   );
   ifr_div u_div_dy (
      .clock(clock), .en(adv), .num_neg(d_yneg_ff),
      .num_mag(d_ymag_ff), .den(d_data_ff.m), .quot(e_dy)
   );
   ifr_div u_div_dz (
      .clock(clock), .en(adv), .num_neg(1'b0),
      .num_mag({1'b0, d_data_ff.h, 30'd0}), .den(d_data_ff.m), .quot(e_dz)
   );

   ifr_delay #(.WIDTH($bits(ifr_l4_type)), .DEPTH(DIV_LAT)) u_line_e (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(d_valid_ff), .in_data(l4_in),
      .out_valid(e_valid), .out_data(e_bits)
   );
   assign e_data = e_bits;

   // stage f: frame select, global axes for a near-vertical normal
   always_comb begin
      f_frame_in          = '0;
      f_frame_in.strike_x = e_data.tiny ? Q30_ONE : e_data.sx;
      f_frame_in.strike_y = e_data.tiny ? '0 : e_data.sy;
      f_frame_in.dip_x    = e_data.tiny ? '0 : e_dx;
      f_frame_in.dip_y    = e_data.tiny ? Q30_ONE : e_dy;
      f_frame_in.dip_z    = e_data.tiny ? '0 : e_dz;
      f_frame_in.axis_n_x = e_data.req.normal_x;
      f_frame_in.axis_n_y = e_data.req.normal_y;
      f_frame_in.axis_n_z = e_data.req.normal_z;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_frame_ff <= f_frame_in;
         f_ps_ff[0] <= $signed(f_frame_in.strike_x) * $signed(e_data.req.vec_x);
         f_ps_ff[1] <= $signed(f_frame_in.strike_y) * $signed(e_data.req.vec_y);
         f_pd_ff[0] <= $signed(f_frame_in.dip_x) * $signed(e_data.req.vec_x);
         f_pd_ff[1] <= $signed(f_frame_in.dip_y) * $signed(e_data.req.vec_y);
         f_pd_ff[2] <= $signed(f_frame_in.dip_z) * $signed(e_data.req.vec_z);
         f_pn_ff[0] <= $signed(e_data.req.normal_x) * $signed(e_data.req.vec_x);
         f_pn_ff[1] <= $signed(e_data.req.normal_y) * $signed(e_data.req.vec_y);
         f_pn_ff[2] <= $signed(e_data.req.normal_z) * $signed(e_data.req.vec_z);
      end
   end

   // stage g: projections, rounded and saturated, into the output register
   always_comb begin
      rsp_in              = f_frame_ff;
      rsp_in.local_first  = dot_round(f_ps_ff[0], f_ps_ff[1], 64'sd0);
      rsp_in.local_second = dot_round(f_pd_ff[0], f_pd_ff[1], f_pd_ff[2]);
      rsp_in.local_third  = dot_round(f_pn_ff[0], f_pn_ff[1], f_pn_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff   <= b_valid;
         d_valid_ff   <= c_valid_ff;
         f_valid_ff   <= e_valid;
         rsp_valid_ff <= f_valid_ff;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_stall_freezes_tail: assert property (@(posedge clock) disable iff (reset)
      (!adv && f_valid_ff) |=> f_valid_ff)
      else $error("transaction lost behind a stalled result");

   a_dip_z_positive: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff || !rsp_ff.dip_z[31])
      else $error("dip z component negative");

endmodule

[rtl/interface_frame_rotation_core.sv]
// ----------------------------------------------------------------------------
// interface_frame_rotation_core
// Builds an orthonormal frame from a surface normal and rotates a global
// vector into it.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive req_data and raise push; the transaction is taken
//   at a clock edge with push high and full low. Result queue side: while
//   empty is low, rsp_data holds the oldest result; pop at an edge with
//   empty low removes it.
//   From acceptance to empty falling a transaction passes through 2 front
//   stages, the queue, 32 square root stages, two 34-stage pipelined
//   dividers in sequence and four arithmetic stages.
//   Throughput is one transaction per cycle while the result side is not
//   stalled, set by the fully pipelined square root and divider units.
//   When the result is not popped the whole back pipeline holds; the front
//   keeps accepting until QUEUE_DEPTH transactions sit in its two stages
//   and the queue together, then raises full.
//   A synchronous reset empties every stage and the queue; full and empty
//   read as not full and empty right after it.
// ----------------------------------------------------------------------------
module interface_frame_rotation_core #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  ifr_pkg::ifr_req_type req_data,
   output logic                 empty,
   input  logic                 pop,
   output ifr_pkg::ifr_rsp_type rsp_data
);
   import ifr_pkg::*;

   logic         q_push;
   ifr_item_type q_in_item;
   logic         q_pop;
   logic         q_empty;
   ifr_item_type q_out_item;

   // accept and classify
   ifr_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock), .reset(reset),
      .push(push), .req_data(req_data), .full(full),
      .q_push(q_push), .q_item(q_in_item), .q_pop(q_pop)
   );

   // decoupling queue
   ifr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_item(q_in_item),
      .pop(q_pop), .empty(q_empty), .pop_item(q_out_item)
   );

   // execute
   ifr_back u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_item(q_out_item), .q_pop(q_pop),
      .pop(pop), .empty(empty), .rsp_data(rsp_data)
   );

endmodule
